// ===== rtl/hsw_pkg.sv =====
// Shared definitions for the Haas stereo widener: codes, gain tables,
// delay constants and the control struct that travels down the pipeline.
// No dependencies.
package hsw_pkg;

  localparam int SLOT_COUNT_DEF  = 4;
  localparam int DELAY_DEPTH_DEF = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int RATE_BITS = 18;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 18'd48000;

  localparam logic KIND_CONFIG = 1'b1;
  localparam logic [2:0] CLASS_OTHER = 3'd4;
  localparam int CLASS_COUNT = 4;

  // Q2.14 gains, center plus side times branch already folded together.
  localparam int GAIN_BITS = 16;
  localparam int GAIN_FRAC = 14;
  typedef logic signed [GAIN_BITS-1:0] gain_t;
  localparam gain_t GAIN_LM [CLASS_COUNT] = '{16'sd17012, 16'sd16056, 16'sd15565, 16'sd17039};
  localparam gain_t GAIN_LD [CLASS_COUNT] = '{16'sd462, 16'sd0, 16'sd0, 16'sd0};
  localparam gain_t GAIN_RM [CLASS_COUNT] = '{16'sd13569, 16'sd9175, 16'sd8192, 16'sd11141};
  localparam gain_t GAIN_RD [CLASS_COUNT] = '{16'sd3905, 16'sd6881, 16'sd7373, 16'sd5898};
  localparam int ROUND_HALF_LSB = 8192;

  // Haas delay per class in milliseconds.
  localparam logic [3:0] CLASS_MSEC [CLASS_COUNT] = '{4'd10, 4'd13, 4'd15, 4'd12};

  // Frames = (rate * ms + 500) / 1000. The division is done as a shift by
  // three and then a multiply by ceil(2^26 / 125), which is exact for
  // every numerator below 2^22.
  localparam int NUM_BITS    = 22;
  localparam logic [NUM_BITS-1:0] MS_ROUND = 22'd500;
  localparam int PRE_SHIFT   = 3;
  localparam int RECIP_BITS  = 20;
  localparam logic [RECIP_BITS-1:0] RECIP_M = 20'd536871;
  localparam int RECIP_SHIFT = 26;
  localparam int QUOT_BITS   = NUM_BITS - PRE_SHIFT + RECIP_BITS - RECIP_SHIFT;

  typedef struct packed {
    logic       bypass;
    logic       hist_ok;
    logic [1:0] cls;
  } hsw_ctl_t;

endpackage

// ===== rtl/hsw_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on hsw_pkg.
interface hsw_item_if import hsw_pkg::*; #(parameter int SB = SAMPLE_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [1:0]           slot;
  logic [2:0]           asset_class;
  logic signed [SB-1:0] left_in;
  logic signed [SB-1:0] right_in;

  modport source (output valid, kind, slot, asset_class, left_in, right_in, input ready);
  modport sink (input valid, kind, slot, asset_class, left_in, right_in, output ready);
endinterface

interface hsw_result_if import hsw_pkg::*; #(parameter int SB = SAMPLE_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [SB-1:0] left_out;
  logic signed [SB-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

// ===== rtl/hsw_delay_ram.sv =====
// Delay line storage for all slots: one write port and one registered read port.
// Depends on hsw_pkg for default sizes.
module hsw_delay_ram import hsw_pkg::*; #(
  parameter int WORDS = SLOT_COUNT_DEF * DELAY_DEPTH_DEF,
  parameter int AW    = $clog2(SLOT_COUNT_DEF * DELAY_DEPTH_DEF),
  parameter int DW    = SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/hsw_delay_calc.sv =====
// Delay table: turns the sample rate into a clamped frame delay per class,
// one class per cycle, after reset and after every sample-rate write.
// Depends on hsw_pkg.
module hsw_delay_calc import hsw_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int AW          = $clog2(DELAY_DEPTH_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [RATE_BITS-1:0] cfg_wr_data,
  output logic [AW-1:0]        delay_tab [CLASS_COUNT],
  output logic                 busy
);

  localparam int QP = NUM_BITS - PRE_SHIFT + RECIP_BITS;

  logic [RATE_BITS-1:0] rate;
  logic                 run;
  logic [1:0]           step;
  logic                 num_valid;
  logic [NUM_BITS-1:0]  num;
  logic [1:0]           num_cls;
  logic [QP-1:0]        quot_prod;
  logic [QUOT_BITS-1:0] quot;
  logic [QUOT_BITS-1:0] quot_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate      <= RATE_RESET;
      run       <= 1'b1;
      step      <= '0;
      num_valid <= 1'b0;
    end else begin
      num_valid <= run;
      if (cfg_wr_en) begin
        rate <= cfg_wr_data;
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == 2'(CLASS_COUNT - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      num     <= NUM_BITS'(rate) * NUM_BITS'(CLASS_MSEC[step]) + MS_ROUND;
      num_cls <= step;
    end
  end

  assign quot_prod = QP'(num[NUM_BITS-1:PRE_SHIFT]) * QP'(RECIP_M);
  assign quot      = quot_prod[QP-1:RECIP_SHIFT];

  always_comb begin
    quot_clamped = quot;
    if (quot == '0) begin
      quot_clamped = QUOT_BITS'(1);
    end else if (quot > QUOT_BITS'(DELAY_DEPTH - 1)) begin
      quot_clamped = QUOT_BITS'(DELAY_DEPTH - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (num_valid) begin
      delay_tab[num_cls] <= quot_clamped[AW-1:0];
    end
  end

  assign busy = run || num_valid;

  for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_tab_chk
    assert property (@(posedge clk) disable iff (rst)
      !busy |-> (delay_tab[g] != '0) && (delay_tab[g] <= AW'(DELAY_DEPTH - 1)))
      else $error("delay table entry out of range");
  end

endmodule

// ===== rtl/hsw_mix.sv =====
// Mixing stages: gain products, round, shift, saturate (or bypass) into the
// output register. Depends on hsw_pkg and hsw_result_if.
module hsw_mix import hsw_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  input  hsw_ctl_t             s1_ctl,
  input  logic signed [SB-1:0] s1_l,
  input  logic signed [SB-1:0] s1_r,
  input  logic signed [SB-1:0] s1_mono,
  input  logic signed [SB-1:0] rd_data,
  output logic                 s2_open,
  hsw_result_if.source         result
);

  localparam int PW = SB + GAIN_BITS;
  localparam int XW = PW + 1 - GAIN_FRAC;

  function automatic logic signed [SB-1:0] sat(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = {{(XW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    lo = {{(XW - SB + 1){1'b1}}, {(SB - 1){1'b0}}};
    if (x > hi) begin
      return hi[SB-1:0];
    end else if (x < lo) begin
      return lo[SB-1:0];
    end
    return x[SB-1:0];
  endfunction

  logic signed [SB-1:0] delayed;
  logic                 out_open;
  logic                 s2_valid;
  logic                 s2_bypass;
  logic signed [SB-1:0] s2_l;
  logic signed [SB-1:0] s2_r;
  logic signed [PW-1:0] p_lm;
  logic signed [PW-1:0] p_ld;
  logic signed [PW-1:0] p_rm;
  logic signed [PW-1:0] p_rd;
  logic signed [PW:0]   acc_l;
  logic signed [PW:0]   acc_r;

  // Entries never written since reset read as silence.
  assign delayed  = s1_ctl.hist_ok ? rd_data : '0;
  assign out_open = !result.valid || result.ready;
  assign s2_open  = !s2_valid || out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_open) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_open && s1_valid) begin
      s2_bypass <= s1_ctl.bypass;
      s2_l      <= s1_l;
      s2_r      <= s1_r;
      p_lm      <= PW'(s1_mono) * PW'(GAIN_LM[s1_ctl.cls]);
      p_ld      <= PW'(delayed) * PW'(GAIN_LD[s1_ctl.cls]);
      p_rm      <= PW'(s1_mono) * PW'(GAIN_RM[s1_ctl.cls]);
      p_rd      <= PW'(delayed) * PW'(GAIN_RD[s1_ctl.cls]);
    end
  end

  assign acc_l = (PW+1)'(p_lm) + (PW+1)'(p_ld) + (PW+1)'(ROUND_HALF_LSB);
  assign acc_r = (PW+1)'(p_rm) + (PW+1)'(p_rd) + (PW+1)'(ROUND_HALF_LSB);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_open) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s2_valid) begin
      result.left_out  <= s2_bypass ? s2_l : sat(acc_l[PW:GAIN_FRAC]);
      result.right_out <= s2_bypass ? s2_r : sat(acc_r[PW:GAIN_FRAC]);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_open |=> s2_valid)
    else $error("product stage dropped while the output was stalled");

endmodule

// ===== rtl/haas_stereo_widener_unit.sv =====
// Haas stereo widener, top level. A sample item's result is held in the
// input, product and output registers in turn; throughput is one item per
// cycle while ready is high, set by the single write and single read port
// of the delay memory.
// Configure items produce no result. Synchronous reset clears all slot state;
// the delay memory needs no clearing pass, since per-slot wrap flags mark which
// entries hold history. After reset and after each sample-rate write, ready is
// low while the delay table is recomputed.
module haas_stereo_widener_unit import hsw_pkg::*; #(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [RATE_BITS-1:0] cfg_wr_data,
  hsw_item_if.sink             item,
  hsw_result_if.source         result
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MW = $clog2(SLOT_COUNT * DELAY_DEPTH);

  logic [AW-1:0] delay_tab [CLASS_COUNT];
  logic          calc_busy;

  logic          slot_active [SLOT_COUNT];
  logic [1:0]    slot_cls    [SLOT_COUNT];
  logic [AW-1:0] slot_dly    [SLOT_COUNT];
  logic [AW-1:0] wp_r        [SLOT_COUNT];
  logic          wrapped     [SLOT_COUNT];

  logic                 accept;
  logic                 in_range;
  logic [SW-1:0]        si;
  logic                 is_cfg;
  logic                 cls_known;
  logic                 run_slot;
  logic                 smp_go;
  logic                 cfg_go;
  logic [AW-1:0]        wp_cur;
  logic [AW-1:0]        d_cur;
  logic [AW:0]          diff;
  logic [AW:0]          diff_wrap;
  logic [AW-1:0]        rp;
  logic [AW-1:0]        wp_next;
  logic                 wp_last;
  logic signed [SB:0]   sum_lr;
  logic signed [SB-1:0] mono;
  logic [MW-1:0]        base;
  logic [MW-1:0]        waddr;
  logic [MW-1:0]        raddr;
  logic [SB-1:0]        mem_rdata;

  logic                 s1_valid;
  hsw_ctl_t             s1_ctl;
  logic signed [SB-1:0] s1_l;
  logic signed [SB-1:0] s1_r;
  logic signed [SB-1:0] s1_mono;
  logic                 s1_open;
  logic                 s2_open;

  hsw_delay_calc #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_calc (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .delay_tab   (delay_tab),
    .busy        (calc_busy)
  );

  assign s1_open    = !s1_valid || s2_open;
  assign item.ready = s1_open && !calc_busy;
  assign accept     = item.valid && item.ready;

  assign in_range  = {3'b000, item.slot} < 5'(SLOT_COUNT);
  assign si        = SW'(item.slot);
  assign is_cfg    = item.kind == KIND_CONFIG;
  assign cls_known = item.asset_class < CLASS_OTHER;
  assign run_slot  = in_range && slot_active[si];
  assign smp_go    = accept && !is_cfg && run_slot;
  assign cfg_go    = accept && is_cfg && in_range;

  assign wp_cur    = wp_r[si];
  assign d_cur     = slot_dly[si];
  assign diff      = {1'b0, wp_cur} - {1'b0, d_cur};
  assign diff_wrap = diff + (AW+1)'(DELAY_DEPTH);
  assign rp        = (wp_cur >= d_cur) ? diff[AW-1:0] : diff_wrap[AW-1:0];
  assign wp_last   = wp_cur == AW'(DELAY_DEPTH - 1);
  assign wp_next   = wp_last ? '0 : wp_cur + AW'(1);

  // Floor of the average: arithmetic shift right by one of the full sum.
  assign sum_lr = (SB+1)'(item.left_in) + (SB+1)'(item.right_in);
  assign mono   = sum_lr[SB:1];

  assign base  = MW'(si) * MW'(DELAY_DEPTH);
  assign waddr = base + MW'(wp_cur);
  assign raddr = base + MW'(rp);

  hsw_delay_ram #(.WORDS(SLOT_COUNT * DELAY_DEPTH), .AW(MW), .DW(SB)) u_ram (
    .clk     (clk),
    .wr_en   (smp_go),
    .wr_addr (waddr),
    .wr_data (mono),
    .rd_en   (smp_go),
    .rd_addr (raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_active[i] <= 1'b0;
        slot_cls[i]    <= '0;
        slot_dly[i]    <= AW'(1);
        wp_r[i]        <= '0;
        wrapped[i]     <= 1'b0;
      end
    end else begin
      if (cfg_go) begin
        if (cls_known) begin
          slot_active[si] <= 1'b1;
          slot_cls[si]    <= item.asset_class[1:0];
          slot_dly[si]    <= delay_tab[item.asset_class[1:0]];
        end else begin
          slot_active[si] <= 1'b0;
          slot_cls[si]    <= '0;
          slot_dly[si]    <= AW'(1);
        end
      end
      if (smp_go) begin
        wp_r[si] <= wp_next;
        if (wp_last) begin
          wrapped[si] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= accept && !is_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_open && accept) begin
      s1_ctl.bypass  <= !run_slot;
      s1_ctl.hist_ok <= wrapped[si] || (rp < wp_cur);
      s1_ctl.cls     <= slot_cls[si];
      s1_l           <= item.left_in;
      s1_r           <= item.right_in;
      s1_mono        <= mono;
    end
  end

  hsw_mix #(.SB(SB)) u_mix (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_l     (s1_l),
    .s1_r     (s1_r),
    .s1_mono  (s1_mono),
    .rd_data  (mem_rdata),
    .s2_open  (s2_open),
    .result   (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    smp_go |-> waddr != raddr)
    else $error("delay read and write hit the same entry");

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_wrap_chk
    assert property (@(posedge clk) disable iff (rst)
      $rose(wrapped[g]) |-> wp_r[g] == '0)
      else $error("wrap flag set without the write position wrapping");
  end

endmodule
